>>> sv/frc_pkg.sv
// Package for the response frame checker: item types, frame constants and
// the byte-wide CRC-16/XMODEM update. No dependencies.
package frc_pkg;

	localparam logic [7:0] START_BYTE0 = 8'hBE;
	localparam logic [7:0] START_BYTE1 = 8'hAA;
	localparam logic [7:0] END_BYTE0   = 8'hEB;
	localparam logic [7:0] END_BYTE1   = 8'hAA;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	localparam int POS_W      = 17;
	localparam int FRAME_OVHD = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int OUT_DATA_W = 40;

	typedef enum logic {
		KIND_DATA    = 1'b0,
		KIND_VERDICT = 1'b1
	} frc_kind_t;

	typedef struct packed {
		frc_kind_t   kind;
		logic [7:0]  payload_byte;
		logic [7:0]  status_byte;
		logic [15:0] data_count;
		logic        frame_good;
	} frc_item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/frc_front.sv
// Front part of the response frame checker: tracks the byte position, the CRC
// and the header fields, and classifies each byte. Depends on frc_pkg.
module frc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             push,
	output frc_pkg::frc_item_t push_item
);
	import frc_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	logic [POS_W-1:0] pos_q, len_ext;
	logic [15:0]      crc_q, crc_d, size_q, size_d;
	logic [7:0]       status_q, status_d, crc_lo_q, crc_lo_d;
	logic             err_q, err_d, emit, good;

	assign len_ext = {1'b0, size_q};

	always_comb begin
		crc_d    = crc_q;
		size_d   = size_q;
		status_d = status_q;
		crc_lo_d = crc_lo_q;
		err_d    = err_q;
		emit     = 1'b0;
		priority if (pos_q == POS_W'(0)) begin
			if (in_byte != START_BYTE0) err_d = 1'b1;
			crc_d = crc_byte(crc_q, in_byte);
		end else if (pos_q == POS_W'(1)) begin
			if (in_byte != START_BYTE1) err_d = 1'b1;
			crc_d = crc_byte(crc_q, in_byte);
		end else if (pos_q == POS_W'(2)) begin
			size_d = {8'h00, in_byte};
			crc_d  = crc_byte(crc_q, in_byte);
		end else if (pos_q == POS_W'(3)) begin
			size_d = {in_byte, size_q[7:0]};
			crc_d  = crc_byte(crc_q, in_byte);
			if ({in_byte, size_q[7:0]} == 16'h0000) err_d = 1'b1;
		end else if (pos_q <= len_ext + POS_W'(3)) begin
			crc_d = crc_byte(crc_q, in_byte);
			if (pos_q == POS_W'(4)) begin
				status_d = in_byte;
			end else begin
				emit = !err_q;
			end
		end else if (pos_q == len_ext + POS_W'(4)) begin
			crc_lo_d = in_byte;
		end else if (pos_q == len_ext + POS_W'(5)) begin
			if ({in_byte, crc_lo_q} != crc_q) err_d = 1'b1;
		end else if (pos_q == len_ext + POS_W'(6)) begin
			if (in_byte != END_BYTE0) err_d = 1'b1;
		end else if (pos_q == len_ext + POS_W'(7)) begin
			if (in_byte != END_BYTE1) err_d = 1'b1;
		end else begin
			err_d = 1'b1;
		end

		good = !err_d && (pos_q >= POS_W'(4)) &&
		       (pos_q == {1'b0, size_d} + POS_W'(FRAME_OVHD - 1));

		if (in_last) begin
			push_item.kind         = KIND_VERDICT;
			push_item.payload_byte = 8'h00;
			push_item.status_byte  = good ? status_d : 8'h00;
			push_item.data_count   = good ? size_d - 16'd1 : 16'h0000;
			push_item.frame_good   = good;
		end else begin
			push_item.kind         = KIND_DATA;
			push_item.payload_byte = in_byte;
			push_item.status_byte  = 8'h00;
			push_item.data_count   = 16'h0000;
			push_item.frame_good   = 1'b0;
		end
		push = in_fire && (in_last || emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= '0;
			size_q   <= '0;
			status_q <= '0;
			crc_lo_q <= '0;
			err_q    <= 1'b0;
		end else if (in_fire) begin
			if (in_last) begin
				pos_q    <= '0;
				crc_q    <= '0;
				size_q   <= '0;
				status_q <= '0;
				crc_lo_q <= '0;
				err_q    <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + POS_W'(1);
				crc_q    <= crc_d;
				size_q   <= size_d;
				status_q <= status_d;
				crc_lo_q <= crc_lo_d;
				err_q    <= err_d;
			end
		end
	end

endmodule

>>> sv/frc_queue.sv
// Short result queue between the front and back parts of the frame checker.
// Depends on frc_pkg.
module frc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  frc_pkg::frc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output frc_pkg::frc_item_t head_item,
	output logic               not_empty
);
	import frc_pkg::*;

	frc_item_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/frc_back.sv
// Back part of the frame checker: drains the result queue into the output
// register of the master stream. Depends on frc_pkg.
module frc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              not_empty,
	input  frc_pkg::frc_item_t                head_item,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [frc_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tuser
);
	import frc_pkg::*;

	frc_item_t out_q;
	logic      valid_q;

	assign pop      = not_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {(OUT_DATA_W - 33)'(0), out_q.frame_good, out_q.data_count,
	                   out_q.status_byte, out_q.payload_byte};

	always_ff @(posedge clk) begin
		if (pop) out_q <= head_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/response_frame_checker_core.sv
// Top level of the response frame checker: front, result queue and back part.
// Depends on frc_pkg, frc_front, frc_queue and frc_back.
//
// The block takes one frame byte per clock cycle on the slave stream and
// checks start bytes, nonzero length, CRC-16/XMODEM, trailer and total
// length. Each payload data byte after the status leaves as a data transfer
// while the frame is still error free, and the byte marked with tlast leaves
// as a verdict transfer. A byte travels through the front part in its accept
// cycle, then through the four-entry queue and the output register.
// s_tready drops only while the four-entry queue is full, so one byte per
// cycle is sustained as long as the master side takes results.
module response_frame_checker_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
	input  logic                           s_tlast,  // end_of_frame
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] payload_byte, [15:8] status_byte, [31:16] data_count,
	// [32] frame_good, [39:33] zero
	output logic [frc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tuser   // item_kind
);
	import frc_pkg::*;

	frc_item_t push_item, head_item;
	logic      push, full, pop, not_empty, in_fire;

	assign s_tready = !full;
	assign in_fire  = s_tvalid && s_tready;

	frc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.push_item (push_item)
	);

	frc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (not_empty)
	);

	frc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head_item (head_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> sv/frc_checker.sv
// Port-level checker for the response frame checker, bound to the top level.
// Depends on frc_pkg.
module frc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [7:0]                     s_tdata,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [frc_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser
);
	import frc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transfer changed while stalled");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DATA) |-> m_tdata[OUT_DATA_W-1:8] == '0)
		else $error("data transfer carries verdict fields");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_VERDICT) && !m_tdata[32] |-> m_tdata[31:0] == '0)
		else $error("bad verdict carries nonzero fields");

	a_good_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_VERDICT) && m_tdata[32] |->
			m_tdata[7:0] == '0 && m_tdata[31:16] != 16'hFFFF)
		else $error("good verdict with payload byte or impossible count");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:33] == '0)
		else $error("padding bits of output data not zero");

endmodule

bind response_frame_checker_core frc_checker u_frc_checker (.*);
